FILE: design/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants for the counting sort engine: default key width and
// default set capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int unsigned KEY_BITS_DEF  = 8;
  localparam int unsigned MAX_ITEMS_DEF = 64;

endpackage : cse_pkg

`default_nettype wire

FILE: design/cse_hist_ram.sv
// ----------------------------------------------------------------------------
// cse_hist_ram
// Histogram store: one bin count per key value, one write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_hist_ram #(
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 7
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule : cse_hist_ram

`default_nettype wire

FILE: design/counting_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// counting_sort_engine_unit
// Counting sort over signed keys. Each key bumps its bin in a histogram
// store; the item flagged last starts a scan from the smallest key upward
// that emits every held key in ascending order and zeroes each bin it reads.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid in_stall in_key in_last_item      | to block
//   out     | out_valid out_stall out_sorted_key         | from block
//           | out_last_out out_overflow                  |
//
// An accepted key reads its bin, then writes it back incremented, in the
// histogram store, which has one read port and one write port; a key that
// finds the set full is dropped and writes nothing. The last item adds a
// scan that reads each bin from the smallest held key up to the largest and
// emits its key once per count. After reset a clearing pass writes every
// bin to zero with in_stall high. The result register lets the next set
// load while the final result still waits on out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_sort_engine_unit
  import cse_pkg::*;
#(
  parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [KEY_BITS-1:0] in_key,
  input  wire logic                       in_last_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [KEY_BITS-1:0]      out_sorted_key,
  output logic                            out_last_out,
  output logic                            out_overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic signed [KEY_BITS-1:0] KEY_MAXV = {1'b0, {(KEY_BITS-1){1'b1}}};
  localparam logic [KEY_BITS-1:0] BIN_LAST = {KEY_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INC,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [KEY_BITS-1:0]         ptr_r, ptr_nxt;
  logic [KEY_BITS-1:0]         inc_bin_r, inc_bin_nxt;
  logic                        inc_last_r, inc_last_nxt;
  logic [CNT_W-1:0]            held_r, held_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic signed [KEY_BITS-1:0]  min_r, min_nxt;
  logic                        dropped_r, dropped_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [KEY_BITS-1:0]  out_key_r, out_key_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                        in_xfer;
  logic                        out_free;
  logic [KEY_BITS-1:0]         in_bin;
  logic                        ram_we;
  logic [KEY_BITS-1:0]         ram_waddr;
  logic [CNT_W-1:0]            ram_wdata;
  logic [KEY_BITS-1:0]         ram_raddr;
  logic [CNT_W-1:0]            ram_rdata;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_bin   = {~in_key[KEY_BITS-1], in_key[KEY_BITS-2:0]};

  cse_hist_ram #(
    .ADDR_W (KEY_BITS),
    .DATA_W (CNT_W)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    inc_bin_nxt   = inc_bin_r;
    inc_last_nxt  = inc_last_r;
    held_nxt      = held_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    min_nxt       = min_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = '0;
    ram_raddr     = ptr_r;

    case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == BIN_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = in_bin;
        if (in_xfer) begin
          if (held_r != MAX_CNT) begin
            inc_bin_nxt  = in_bin;
            inc_last_nxt = in_last_item;
            held_nxt     = held_r + 1'b1;
            if (in_key < min_r) begin
              min_nxt = in_key;
            end
            state_nxt = S_INC;
          end else begin
            dropped_nxt = 1'b1;
            if (in_last_item) begin
              rem_nxt   = held_r;
              ptr_nxt   = {~min_r[KEY_BITS-1], min_r[KEY_BITS-2:0]};
              state_nxt = S_SCAN_RD;
            end
          end
        end
      end
      S_INC: begin
        ram_we    = 1'b1;
        ram_waddr = inc_bin_r;
        ram_wdata = ram_rdata + 1'b1;
        if (inc_last_r) begin
          rem_nxt   = held_r;
          ptr_nxt   = {~min_r[KEY_BITS-1], min_r[KEY_BITS-2:0]};
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        ram_we  = 1'b1;
        cnt_nxt = ram_rdata;
        if (ram_rdata == '0) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = {~ptr_r[KEY_BITS-1], ptr_r[KEY_BITS-2:0]};
          out_last_nxt  = (rem_r == ONE_CNT);
          out_ovf_nxt   = dropped_r;
          rem_nxt       = rem_r - 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          if (rem_r == ONE_CNT) begin
            held_nxt    = '0;
            min_nxt     = KEY_MAXV;
            dropped_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else if (cnt_r == ONE_CNT) begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        ptr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      held_r      <= '0;
      min_r       <= KEY_MAXV;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      held_r      <= held_nxt;
      min_r       <= min_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    inc_bin_r  <= inc_bin_nxt;
    inc_last_r <= inc_last_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_last_out   = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule : counting_sort_engine_unit

`default_nettype wire
